// ===== rtl/core/supersample_outline_glyph_shader_defines.svh =====
`ifndef SUPERSAMPLE_OUTLINE_GLYPH_SHADER_DEFINES_SVH
`define SUPERSAMPLE_OUTLINE_GLYPH_SHADER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SSOG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define SSOG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state in the cycle after reset is seen
`define SSOG_ASSERT_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssog_pkg.sv =====
`default_nettype none

package ssog_pkg;

  // channel and color layout
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned NUM_CHAN  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // default upper bound on the supersample factor
  localparam int unsigned MAX_SUPERSAMPLE_DEF = 8;

  // restoring divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = CHAN_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUPERSAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 2'd2;

  // register reset values
  localparam logic [3:0]         FACTOR_RESET     = 4'd3;
  localparam logic [COLOR_W-1:0] EDGE_COLOR_RESET = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RESET = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_first;
    logic mul_en;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

  // subpixels per pixel for a raw factor, clamped to 1..max_q
  function automatic logic [8:0] calc_q2(input logic [3:0] factor, input int unsigned max_q);
    logic [4:0] q;
    begin
      q = (factor == 4'd0) ? 5'd1 : {1'b0, factor};
      if (32'(q) > max_q) q = 5'(max_q);
      return {4'b0, q} * {4'b0, q};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/supersample_outline_glyph_shader.sv =====
// a pixel's last subpixel starts divide, product and load; the load sets out_valid
// one subpixel per cycle while accumulating; in_stall holds subpixels off while busy
// busy window: 8-step restoring divide per lane, shared divisor, then product and load
// the load waits while the output register still holds an untaken pixel
// reset (rst, synchronous): registers to defaults, sums and count cleared, output empty
`default_nettype none

module supersample_outline_glyph_shader #(
  parameter int unsigned MAX_SUPERSAMPLE = ssog_pkg::MAX_SUPERSAMPLE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ssog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssog_pkg::COLOR_W-1:0]    cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ssog_pkg::CHAN_W-1:0]     background_level,
  input  wire logic [ssog_pkg::CHAN_W-1:0]     edge_level,
  input  wire logic [ssog_pkg::CHAN_W-1:0]     fill_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ssog_pkg::CHAN_W-1:0]          alpha_out,
  output logic [ssog_pkg::CHAN_W-1:0]          red_out,
  output logic [ssog_pkg::CHAN_W-1:0]          green_out,
  output logic [ssog_pkg::CHAN_W-1:0]          blue_out
);
  import ssog_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register writes are always accepted, cfg_ready is tied high
  assign cfg_ready = 1'b1;

  ssog_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ssog_datapath #(
    .MAX_SUPERSAMPLE (MAX_SUPERSAMPLE)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .background_level (background_level),
    .edge_level       (edge_level),
    .fill_level       (fill_level),
    .cmd              (cmd),
    .status           (status),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .alpha_out        (alpha_out),
    .red_out          (red_out),
    .green_out        (green_out),
    .blue_out         (blue_out)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ssog_ctrl.sv =====
`default_nettype none

module ssog_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  ssog_pkg::status_t    status,
  output ssog_pkg::cmd_t       cmd
);
  import ssog_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCUM = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  // subpixels are taken only while accumulating
  assign in_stall = (state != ST_ACCUM);

  // command decode and next state
  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    unique case (state)
      ST_ACCUM: begin
        cmd.accept = in_valid;
        step_next  = '0;
        if (in_valid && status.last) state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step == '0);
        step_next     = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.out_load = status.out_free;
        if (status.out_free) state_next = ST_ACCUM;
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssog_datapath.sv =====
`default_nettype none

module ssog_datapath #(
  parameter int unsigned MAX_SUPERSAMPLE = ssog_pkg::MAX_SUPERSAMPLE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [ssog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssog_pkg::COLOR_W-1:0]    cfg_data,
  input  wire logic [ssog_pkg::CHAN_W-1:0]     background_level,
  input  wire logic [ssog_pkg::CHAN_W-1:0]     edge_level,
  input  wire logic [ssog_pkg::CHAN_W-1:0]     fill_level,
  input  ssog_pkg::cmd_t                       cmd,
  output ssog_pkg::status_t                    status,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic [ssog_pkg::CHAN_W-1:0]          alpha_out,
  output logic [ssog_pkg::CHAN_W-1:0]          red_out,
  output logic [ssog_pkg::CHAN_W-1:0]          green_out,
  output logic [ssog_pkg::CHAN_W-1:0]          blue_out
);
  import ssog_pkg::*;

  localparam int unsigned CNT_W     = $clog2(MAX_SUPERSAMPLE * MAX_SUPERSAMPLE + 1);
  localparam int unsigned CNT_EXT_W = CNT_W + 1;
  localparam int unsigned SUM_W     = CHAN_W + $clog2(MAX_SUPERSAMPLE * MAX_SUPERSAMPLE);
  localparam int unsigned DIV_W     = SUM_W + 1;
  localparam int unsigned PROD_W    = 2 * CHAN_W;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LANE_BG   = 0;
  localparam int unsigned LANE_EDGE = 1;
  localparam int unsigned LANE_FILL = 2;
  localparam int unsigned CH_ALPHA  = 3;
  localparam int unsigned CH_RED    = 2;
  localparam int unsigned CH_GREEN  = 1;
  localparam int unsigned CH_BLUE   = 0;
  localparam logic [CNT_W-1:0] Q2_RESET = CNT_W'(calc_q2(FACTOR_RESET, MAX_SUPERSAMPLE));

  // configuration state
  logic [CNT_W-1:0]   q2;
  logic [COLOR_W-1:0] edge_color;
  logic [COLOR_W-1:0] fill_color;

  // accumulation and division state
  logic [CHAN_W-1:0]  lvl       [NUM_LANES];
  logic [SUM_W-1:0]   lane_sum  [NUM_LANES];
  logic [SUM_W-1:0]   rem       [NUM_LANES];
  logic [CHAN_W-1:0]  quot      [NUM_LANES];
  logic               sat       [NUM_LANES];
  logic [CHAN_W-1:0]  avg       [NUM_LANES];
  logic [CNT_W-1:0]   count;
  logic [CNT_EXT_W-1:0] count_inc;
  logic               last;
  logic [DIV_W-1:0]   divisor;

  // blend state
  logic [PROD_W-1:0]  prod_e    [NUM_CHAN];
  logic [PROD_W-1:0]  prod_f    [NUM_CHAN];
  logic               bg_nz;
  logic [CHAN_W-1:0]  px_next   [NUM_CHAN];
  logic [CHAN_W-1:0]  px        [NUM_CHAN];

  assign lvl[LANE_BG]   = background_level;
  assign lvl[LANE_EDGE] = edge_level;
  assign lvl[LANE_FILL] = fill_level;

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      q2         <= Q2_RESET;
      edge_color <= EDGE_COLOR_RESET;
      fill_color <= FILL_COLOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SUPERSAMPLE: q2 <= CNT_W'(calc_q2(cfg_data[3:0], MAX_SUPERSAMPLE));
        CFG_EDGE_COLOR:  edge_color <= cfg_data;
        CFG_FILL_COLOR:  fill_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // pixel completes once the count reaches the subpixel total
  assign count_inc   = CNT_EXT_W'(count) + CNT_EXT_W'(1);
  assign last        = (count_inc >= CNT_EXT_W'(q2));
  assign status.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      count <= last ? '0 : count_inc[CNT_W-1:0];
    end
  end

  // divisor walks down from q2 shifted to the top quotient bit
  always_ff @(posedge clk) begin
    if (cmd.accept && last) begin
      divisor <= DIV_W'(q2) << (DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      divisor <= divisor >> 1;
    end
  end

  // per-lane accumulate and restoring divide
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic ge;

    assign ge     = ({1'b0, rem[i]} >= divisor);
    assign avg[i] = sat[i] ? {CHAN_W{1'b1}} : quot[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        lane_sum[i] <= '0;
      end else if (cmd.accept) begin
        lane_sum[i] <= last ? '0 : lane_sum[i] + SUM_W'(lvl[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.accept && last) begin
        rem[i] <= lane_sum[i] + SUM_W'(lvl[i]);
      end else if (cmd.div_step && ge) begin
        rem[i] <= rem[i] - divisor[SUM_W-1:0];
      end
      if (cmd.div_step) begin
        quot[i] <= {quot[i][CHAN_W-2:0], ge};
      end
      // average above the channel range clamps
      if (cmd.div_step && cmd.div_first) begin
        sat[i] <= ({2'b0, rem[i]} >= {divisor, 1'b0});
      end
    end
  end

  // products, registered before the channel sums
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      bg_nz <= (avg[LANE_BG] != '0);
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    logic [CHAN_W-1:0] op_e;
    logic [CHAN_W-1:0] op_f;
    logic [CHAN_W:0]   blend_sum;

    // with background left, alpha scales by inverse background and fill drops out
    always_comb begin
      op_e = avg[LANE_EDGE];
      op_f = avg[LANE_FILL];
      if (avg[LANE_BG] != '0) begin
        op_f = '0;
        if (c == CH_ALPHA) op_e = ~avg[LANE_BG];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.mul_en) begin
        prod_e[c] <= {{CHAN_W{1'b0}}, edge_color[CHAN_W*c +: CHAN_W]} * {{CHAN_W{1'b0}}, op_e};
        prod_f[c] <= {{CHAN_W{1'b0}}, fill_color[CHAN_W*c +: CHAN_W]} * {{CHAN_W{1'b0}}, op_f};
      end
    end

    // channel sum with saturation
    assign blend_sum = {1'b0, prod_e[c][PROD_W-1:CHAN_W]} + {1'b0, prod_f[c][PROD_W-1:CHAN_W]};

    always_comb begin
      if (bg_nz && (c != CH_ALPHA)) begin
        px_next[c] = edge_color[CHAN_W*c +: CHAN_W];
      end else if (blend_sum[CHAN_W]) begin
        px_next[c] = {CHAN_W{1'b1}};
      end else begin
        px_next[c] = blend_sum[CHAN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.out_load) begin
        px[c] <= px_next[c];
      end
    end
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign alpha_out = px[CH_ALPHA];
  assign red_out   = px[CH_RED];
  assign green_out = px[CH_GREEN];
  assign blue_out  = px[CH_BLUE];

endmodule

`default_nettype wire

// ===== rtl/core/ssog_checker.sv =====
`default_nettype none
`include "supersample_outline_glyph_shader_defines.svh"

module ssog_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] alpha_out,
  input wire logic [7:0] red_out,
  input wire logic [7:0] green_out,
  input wire logic [7:0] blue_out
);

  // reset leaves the block empty and ready for subpixels
  `SSOG_ASSERT_RESET(a_reset_idle, clk, rst, !out_valid && !in_stall, "not idle after reset")

  // a stalled pixel stays offered and unchanged
  `SSOG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(alpha_out) && $stable(red_out) && $stable(green_out) && $stable(blue_out), "stalled pixel changed")

  // once a pixel closes the block stays busy through the divide
  `SSOG_ASSERT_NEXT(a_busy_span, clk, rst, $rose(in_stall), in_stall, "busy window too short")

  // leaving the busy window always hands a pixel to the output register
  `SSOG_ASSERT_NOW(a_result_on_release, clk, rst, $fell(in_stall), out_valid, "busy ended without a pixel")

  // a new pixel appears only at the end of a busy window
  `SSOG_ASSERT_NOW(a_result_source, clk, rst, $rose(out_valid), $fell(in_stall), "pixel without a busy window")

endmodule

bind supersample_outline_glyph_shader ssog_checker u_ssog_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ssog_pkg::*;

  localparam int unsigned MAX_Q        = MAX_SUPERSAMPLE_DEF;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned SETTLE_WAIT  = 24;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned STALL_LIMIT  = 2000;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] bg;
    logic [CHAN_W-1:0] edge_lvl;
    logic [CHAN_W-1:0] fill_lvl;
  } subpixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef enum int {
    MIX_RANDOM, BG_CLEAR, FULL_COVER, BG_SPARSE, BG_SOLID, BLANK
  } pixel_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAN_W-1:0]    background_level = '0;
  logic [CHAN_W-1:0]    edge_level = '0;
  logic [CHAN_W-1:0]    fill_level = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAN_W-1:0]    alpha_out;
  logic [CHAN_W-1:0]    red_out;
  logic [CHAN_W-1:0]    green_out;
  logic [CHAN_W-1:0]    blue_out;

  // pending subpixels and pixels still owed by the block
  subpixel_t   subpixel_q[$];
  pixel_t      pixel_q[$];

  // register mirror
  logic [3:0]         factor_reg;
  logic [COLOR_W-1:0] edge_argb;
  logic [COLOR_W-1:0] fill_argb;

  // accumulator mirror
  logic [13:0] bg_sum;
  logic [13:0] edge_sum;
  logic [13:0] fill_sum;
  logic [6:0]  subpixel_cnt;

  int unsigned idle_pct = 20;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned subpixels_taken = 0;
  int unsigned pixels_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned random_queued = 0;

  supersample_outline_glyph_shader u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .background_level (background_level),
    .edge_level       (edge_level),
    .fill_level       (fill_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .alpha_out        (alpha_out),
    .red_out          (red_out),
    .green_out        (green_out),
    .blue_out         (blue_out)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // subpixels per pixel for a raw factor, with 0 acting as 1 and clamp at max
  function automatic int unsigned pixel_area(input logic [3:0] factor);
    int unsigned q;
    q = (factor == 4'd0) ? 1 : int'(factor);
    if (q > MAX_Q) q = MAX_Q;
    return q * q;
  endfunction

  // weighted sum of edge and fill contributions, saturated
  function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] ec,
                                                    input logic [CHAN_W-1:0] fc,
                                                    input int unsigned e_avg,
                                                    input int unsigned f_avg);
    int unsigned s;
    s = ((int'(ec) * e_avg) >> 8) + ((int'(fc) * f_avg) >> 8);
    return (s > 255) ? 8'hFF : 8'(s);
  endfunction

  // accumulate one subpixel, push the pixel when the box is full
  task automatic shade_subpixel(input subpixel_t sp);
    int unsigned area, avg_bg, avg_edge, avg_fill;
    pixel_t px;
    area = pixel_area(factor_reg);
    bg_sum       = bg_sum + sp.bg;
    edge_sum     = edge_sum + sp.edge_lvl;
    fill_sum     = fill_sum + sp.fill_lvl;
    subpixel_cnt = subpixel_cnt + 1'b1;
    if (subpixel_cnt < area) return;
    avg_bg   = bg_sum / area;
    avg_edge = edge_sum / area;
    avg_fill = fill_sum / area;
    if (avg_bg > 255) avg_bg = 255;
    if (avg_edge > 255) avg_edge = 255;
    if (avg_fill > 255) avg_fill = 255;
    if (avg_bg > 0) begin
      px.alpha = 8'(((255 - avg_bg) * int'(edge_argb[31:24])) >> 8);
      px.red   = edge_argb[23:16];
      px.green = edge_argb[15:8];
      px.blue  = edge_argb[7:0];
    end else begin
      px.alpha = mix_channel(edge_argb[31:24], fill_argb[31:24], avg_edge, avg_fill);
      px.red   = mix_channel(edge_argb[23:16], fill_argb[23:16], avg_edge, avg_fill);
      px.green = mix_channel(edge_argb[15:8], fill_argb[15:8], avg_edge, avg_fill);
      px.blue  = mix_channel(edge_argb[7:0], fill_argb[7:0], avg_edge, avg_fill);
    end
    pixel_q.push_back(px);
    bg_sum       = '0;
    edge_sum     = '0;
    fill_sum     = '0;
    subpixel_cnt = '0;
  endtask

  // register mirror follows every config transaction
  always @(posedge clk) begin
    if (rst) begin
      factor_reg <= FACTOR_RESET;
      edge_argb  <= EDGE_COLOR_RESET;
      fill_argb  <= FILL_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reg_writes <= reg_writes + 1;
      case (cfg_index)
        CFG_SUPERSAMPLE: factor_reg <= cfg_data[3:0];
        CFG_EDGE_COLOR:  edge_argb <= cfg_data;
        CFG_FILL_COLOR:  fill_argb <= cfg_data;
        default: ;
      endcase
    end
  end

  // subpixel driver with random gap bursts
  always @(posedge clk) begin
    subpixel_t sp;
    if (rst) begin
      in_valid     <= 1'b0;
      bg_sum       = '0;
      edge_sum     = '0;
      fill_sum     = '0;
      subpixel_cnt = '0;
    end else begin
      if (in_valid && !in_stall) begin
        shade_subpixel({background_level, edge_level, fill_level});
        subpixels_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (subpixel_q.size() > 0) begin
          sp = subpixel_q.pop_front();
          in_valid         <= 1'b1;
          background_level <= sp.bg;
          edge_level       <= sp.edge_lvl;
          fill_level       <= sp.fill_lvl;
          if ($urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor and output stall generation
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("pixel transaction with nothing expected: %h %h %h %h",
                 alpha_out, red_out, green_out, blue_out);
          errors++;
        end else begin
          exp_px = pixel_q.pop_front();
          pixels_checked++;
          if (alpha_out !== exp_px.alpha) begin
            $error("alpha_out: expected %0d, got %0d", exp_px.alpha, alpha_out);
            errors++;
          end
          if (red_out !== exp_px.red) begin
            $error("red_out: expected %0d, got %0d", exp_px.red, red_out);
            errors++;
          end
          if (green_out !== exp_px.green) begin
            $error("green_out: expected %0d, got %0d", exp_px.green, green_out);
            errors++;
          end
          if (blue_out !== exp_px.blue) begin
            $error("blue_out: expected %0d, got %0d", exp_px.blue, blue_out);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_subpixel(input logic [7:0] bg, input logic [7:0] el,
                                input logic [7:0] fl);
    subpixel_q.push_back({bg, el, fl});
  endtask

  // one box worth of subpixels in a given coverage style
  task automatic queue_pixel(input int unsigned count, input pixel_style_t style);
    logic [7:0] bg, el, fl;
    for (int unsigned i = 0; i < count; i++) begin
      bg = 8'($urandom);
      el = 8'($urandom);
      fl = 8'($urandom);
      case (style)
        BG_CLEAR:   bg = 8'd0;
        FULL_COVER: begin
          bg = 8'd0;
          el = 8'hFF;
          fl = 8'hFF;
        end
        BG_SPARSE:  bg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
        BG_SOLID:   bg = 8'hFF;
        BLANK: begin
          bg = 8'd0;
          el = 8'd0;
          fl = 8'd0;
        end
        default: ;
      endcase
      queue_subpixel(bg, el, fl);
      random_queued++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every owed pixel is out and the pipe has drained
  task automatic wait_idle();
    while (subpixel_q.size() != 0 || in_valid || pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // stimulus sequence
  initial begin
    int unsigned phase, area, npix, pick;
    logic [3:0] factor;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset colors and reset factor, full coverage saturates
    repeat (9) queue_subpixel(8'd0, 8'hFF, 8'hFF);
    wait_idle();

    // factor 0 acts as 1, spare index must not touch the factor
    write_reg(CFG_SUPERSAMPLE, 32'd0);
    write_reg(CFG_SPARE, 32'h0000_0008);
    queue_subpixel(8'hFF, 8'h00, 8'h00);
    queue_subpixel(8'h01, 8'hFF, 8'hFF);
    queue_subpixel(8'h00, 8'h00, 8'h00);
    queue_subpixel(8'h00, 8'hFF, 8'hFF);
    queue_subpixel(8'h00, 8'h80, 8'h7F);
    queue_subpixel(8'h00, 8'h7F, 8'h80);
    queue_subpixel(8'h80, 8'h55, 8'hAA);
    queue_subpixel(8'h00, 8'h55, 8'hAA);
    wait_idle();

    // factor lowered mid-pixel, averages overflow and clamp
    write_reg(CFG_SUPERSAMPLE, 32'd3);
    repeat (5) queue_subpixel(8'd0, 8'hFF, 8'hFF);
    wait_idle();
    write_reg(CFG_SUPERSAMPLE, 32'd2);
    queue_subpixel(8'd0, 8'hFF, 8'hFF);

    // random phases, each with its own register setting
    phase = 0;
    while (random_queued < RANDOM_ITEMS) begin
      wait_idle();
      if (random_queued > RANDOM_ITEMS * 5 / 6) idle_pct = 0;
      else idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      pick = $urandom_range(0, 9);
      case (pick)
        0:       factor = 4'd0;
        4:       factor = 4'd4;
        5:       factor = 4'($urandom_range(5, 8));
        6:       factor = 4'($urandom_range(9, 15));
        default: factor = 4'($urandom_range(1, 3));
      endcase
      if (phase == 1) factor = 4'd1;
      write_reg(CFG_SUPERSAMPLE, (32'($urandom) & 32'hFFFF_FFF0) | 32'(factor));
      if (phase == 0 || $urandom_range(0, 1) == 0) write_reg(CFG_EDGE_COLOR, pick_color());
      if (phase == 0 || $urandom_range(0, 1) == 0) write_reg(CFG_FILL_COLOR, pick_color());
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, $urandom);
      area = pixel_area(factor);
      npix = (area >= 50) ? 1 : 50 / area;
      for (int unsigned i = 0; i < npix; i++)
        queue_pixel(area, pixel_style_t'($urandom_range(0, 5)));
      // long output hold while subpixels keep coming
      if (phase == 1) hold_requests++;
      // leave a partial pixel for the next setting to finish
      if (area > 1 && $urandom_range(0, 2) == 0)
        queue_pixel($urandom_range(1, area - 1), pixel_style_t'($urandom_range(0, 5)));
      phase++;
    end

    wait_idle();
    $display("checked %0d pixels from %0d subpixels across %0d register writes",
             pixels_checked, subpixels_taken, reg_writes);
    $display("factors 0 to 15, color extremes, mid-pixel factor changes and long stalls");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
